### src/moa_pkg.sv
// Shared types for the median block: item payloads and the
// controller-to-datapath command and status groups. No dependencies.
package moa_pkg;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               last_item;
  } moa_in_t;

  typedef struct packed {
    logic signed [31:0] median_value;
    logic               overflow_flag;
    logic [6:0]         element_count;
  } moa_out_t;

  typedef struct packed {
    logic store_item;
    logic pos_init;
    logic rd_sort;
    logic rd_med;
    logic step_up;
    logic swap_hi;
    logic swap_lo;
    logic load_out;
    logic clear_set;
  } moa_cmd_t;

  typedef struct packed {
    logic pos_done;
    logic in_order;
  } moa_status_t;

endpackage

### src/median_of_array.sv
// Median of a set of signed 32-bit samples, sorted in place by gnome sort.
// Top level; depends on moa_pkg, moa_ctrl and moa_dp.
//
// Input channel (in_valid/in_ready/in_data) takes one sample per cycle while
// a set is loading; last_item closes the set. Up to MAX_COUNT samples are
// stored; later ones are dropped and reported in overflow_flag.
// After the last item the block sorts the store in its single memory (two
// read ports, one write port): a compare step reads a neighbouring pair and
// compares it, a swap step writes the pair back in exchanged order. The
// middle pair is then fetched and averaged. in_ready is low for that whole
// time.
// Output channel (out_valid/out_ready/out_data) carries one result per set
// from an output register. Loading of the next set goes on while a result
// waits; a set that finishes while the previous result is still not taken
// holds in its final state until out_ready frees the register.
// Reset (rst_n low, synchronous) empties the set and drops any pending
// result; the store itself is not cleared.
module median_of_array import moa_pkg::*; #(
  parameter int MAX_COUNT = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  moa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output moa_out_t out_data
);

  moa_cmd_t    cmd;
  moa_status_t status;

  moa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  moa_dp #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

### src/moa_ctrl.sv
// Sequencer for the median block: load, gnome sort steps, median fetch.
// Depends on moa_pkg.
module moa_ctrl import moa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  moa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  moa_status_t status,
  output moa_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_SWP,
    ST_MED
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          cmd.store_item = 1'b1;
          if (in_data.last_item) begin
            cmd.pos_init = 1'b1;
            state_nxt    = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        if (status.pos_done) begin
          cmd.rd_med = 1'b1;
          state_nxt  = ST_MED;
        end else begin
          cmd.rd_sort = 1'b1;
          state_nxt   = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (status.in_order) begin
          cmd.step_up = 1'b1;
          state_nxt   = ST_SORT_RD;
        end else begin
          cmd.swap_hi = 1'b1;
          state_nxt   = ST_SORT_SWP;
        end
      end
      ST_SORT_SWP: begin
        cmd.swap_lo = 1'b1;
        state_nxt   = ST_SORT_RD;
      end
      ST_MED: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          cmd.clear_set = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/moa_dp.sv
// Datapath for the median block: sample store, fill count, sort position,
// compare, swap and median arithmetic, output register. Depends on moa_pkg.
module moa_dp import moa_pkg::*; #(
  parameter int MAX_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  moa_in_t     in_data,
  input  moa_cmd_t    cmd,
  output moa_status_t status,
  output moa_out_t    out_data
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int EW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [MAX_COUNT];

  logic [CW-1:0]      fill_r;
  logic               dropped_r;
  logic [CW-1:0]      pos_r;
  logic signed [31:0] rd_hi_r;
  logic signed [31:0] rd_lo_r;
  moa_out_t           out_r;

  logic               full;
  logic [CW-1:0]      pos_dec;
  logic [CW-1:0]      fill_dec;
  logic [AW-1:0]      addr_hi;
  logic [AW-1:0]      addr_lo;
  logic [AW-1:0]      addr_wr;
  logic               wr_en;
  logic signed [31:0] wr_data;
  logic signed [32:0] sum;
  logic signed [32:0] half;
  logic [EW-1:0]      count_ext;

  assign full     = (fill_r == CW'(MAX_COUNT));
  assign pos_dec  = pos_r - CW'(1);
  assign fill_dec = fill_r - CW'(1);

  always_comb begin
    if (cmd.rd_med) begin
      addr_hi = AW'(fill_r >> 1);
      addr_lo = AW'(fill_dec >> 1);
    end else begin
      addr_hi = pos_r[AW-1:0];
      addr_lo = pos_dec[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    addr_wr = pos_r[AW-1:0];
    wr_data = rd_lo_r;
    if (cmd.store_item) begin
      wr_en   = !full;
      addr_wr = fill_r[AW-1:0];
      wr_data = in_data.sample_value;
    end else if (cmd.swap_hi) begin
      wr_en   = 1'b1;
      addr_wr = pos_r[AW-1:0];
      wr_data = rd_lo_r;
    end else if (cmd.swap_lo) begin
      wr_en   = 1'b1;
      addr_wr = pos_dec[AW-1:0];
      wr_data = rd_hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_wr] <= wr_data;
    end
    if (cmd.rd_sort || cmd.rd_med) begin
      rd_hi_r <= mem[addr_hi];
      rd_lo_r <= mem[addr_lo];
    end
  end

  assign status.pos_done = (pos_r >= fill_r);
  assign status.in_order = (rd_hi_r >= rd_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
      pos_r     <= CW'(1);
    end else begin
      if (cmd.store_item) begin
        if (full) begin
          dropped_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CW'(1);
        end
      end
      if (cmd.clear_set) begin
        fill_r    <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.pos_init) begin
        pos_r <= CW'(1);
      end else if (cmd.step_up) begin
        pos_r <= pos_r + CW'(1);
      end else if (cmd.swap_lo) begin
        pos_r <= (pos_r == CW'(1)) ? CW'(1) : pos_dec;
      end
    end
  end

  // sum of middle pair, halved toward zero; odd count reads one entry twice
  assign sum       = {rd_hi_r[31], rd_hi_r} + {rd_lo_r[31], rd_lo_r};
  assign half      = (sum + {32'b0, sum[32]}) >>> 1;
  assign count_ext = EW'(fill_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.median_value  <= half[31:0];
      out_r.overflow_flag <= dropped_r;
      out_r.element_count <= count_ext[6:0];
    end
  end

  assign out_data = out_r;

endmodule

### test/median_of_array_test.sv
`timescale 1ns / 100ps
// Testbench for median_of_array: random and directed sample sets go through the
// valid/ready input, and each median is checked against a sorted copy of the set.
// Depends on moa_pkg and the median_of_array RTL.
module median_of_array_test;
  import moa_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int ITEM_TARGET = 1250;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam int SEND_IDLE_PCT[4] = '{0, 59, 0, 16};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 59, 16};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  moa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  moa_out_t out_data;

  moa_in_t  pending_samples[$];
  moa_out_t expected_medians[$];
  logic signed [31:0] held_values[STORE_DEPTH];
  int       held_count = 0;
  bit       held_dropped = 1'b0;
  bit       in_taken = 1'b0;
  int       items_sent = 0;
  int       items_total = 1;
  int       set_len = 0;
  int       mismatches = 0;
  longint   cycle_count = 0;
  longint   cycle_budget = 0;
  longint   cycle_limit = 64'd1000000000;

  median_of_array #(.MAX_COUNT(STORE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_phase();
    int p;
    p = items_sent * 4 / items_total;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 75) return $urandom_range(6) - 3;
    case ($urandom_range(3))
      0: return S_MIN;
      1: return S_MAX;
      2: return S_MIN + 1;
      default: return S_MAX - 1;
    endcase
  endfunction

  // queue one item; on the last of a set, add a cycle allowance for sorting it
  task automatic queue_sample(logic signed [31:0] v, logic last);
    moa_in_t it;
    int kept;
    it.sample_value = v;
    it.last_item = last;
    pending_samples.push_back(it);
    set_len++;
    if (last) begin
      kept = (set_len > STORE_DEPTH) ? STORE_DEPTH : set_len;
      cycle_budget += 8 * set_len + 2 * kept * kept + 40;
      set_len = 0;
    end
  endtask

  task automatic queue_pair(logic signed [31:0] a, logic signed [31:0] b);
    queue_sample(a, 1'b0);
    queue_sample(b, 1'b1);
  endtask

  task automatic queue_random_set();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 85) n = $urandom_range(1, 8);
    else if (r < 95) n = $urandom_range(9, 32);
    else if (r < 98) n = $urandom_range(60, 64);
    else n = $urandom_range(65, 70);
    for (int i = 0; i < n; i++) queue_sample(pick_sample(), i == n - 1);
  endtask

  // median of the held set: sorted copy, middle element or middle pair averaged
  task automatic absorb_sample(moa_in_t it);
    logic signed [31:0] ord[STORE_DEPTH];
    logic signed [31:0] t;
    longint pair_sum;
    moa_out_t want;
    int j;
    if (held_count < STORE_DEPTH) begin
      held_values[held_count] = it.sample_value;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (it.last_item) begin
      for (int i = 0; i < held_count; i++) begin
        t = held_values[i];
        j = i;
        while (j > 0 && ord[j - 1] > t) begin
          ord[j] = ord[j - 1];
          j--;
        end
        ord[j] = t;
      end
      if (held_count % 2 == 1) begin
        want.median_value = ord[held_count / 2];
      end else begin
        pair_sum = longint'(ord[held_count / 2 - 1]) + longint'(ord[held_count / 2]);
        want.median_value = 32'(pair_sum / 2);
      end
      want.overflow_flag = held_dropped;
      want.element_count = 7'(held_count);
      expected_medians.push_back(want);
      held_count = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(moa_out_t got);
    moa_out_t want;
    if (expected_medians.size() == 0) begin
      report_mismatch("result with none expected, median", got.median_value, 0);
    end else begin
      want = expected_medians.pop_front();
      if (got.median_value !== want.median_value)
        report_mismatch("median_value", got.median_value, want.median_value);
      if (got.overflow_flag !== want.overflow_flag)
        report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
      if (got.element_count !== want.element_count)
        report_mismatch("element_count", got.element_count, want.element_count);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      absorb_sample(in_data);
      pending_samples.delete(0);
      items_sent++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_samples.size() > 0 &&
          $urandom_range(99) >= SEND_IDLE_PCT[idle_phase()]) begin
        in_data  <= pending_samples[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= RECV_STALL_PCT[idle_phase()]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // single element, middle-pair sums that overflow 32 bits, truncation toward zero
    queue_sample(S_MAX, 1'b1);
    queue_sample(S_MIN, 1'b1);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair(-32'sd3, 32'sd0);
    queue_pair(32'sd3, 32'sd0);
    queue_sample(32'sd3, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd2, 1'b1);
    queue_sample(32'sd5, 1'b0);
    queue_sample(-32'sd7, 1'b0);
    queue_sample(32'sd0, 1'b0);
    queue_sample(-32'sd2, 1'b1);
    // full store in descending order; the last two items, last one included, dropped
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      queue_sample(32'sd1000 - i * 37, i == STORE_DEPTH + 1);
    while (pending_samples.size() < ITEM_TARGET) queue_random_set();
    items_total = pending_samples.size();
    cycle_limit = 4 * cycle_budget + 20000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_samples.size() > 0 || expected_medians.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### median_of_array.f
src/moa_pkg.sv
src/moa_ctrl.sv
src/moa_dp.sv
src/median_of_array.sv
test/median_of_array_test.sv
